@@ rtl/core/qra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_pkg
// Shared widths, register indexes and item types of the quadrupole-rate
// accumulator.
// ----------------------------------------------------------------------------
package qra_pkg;

    // field widths
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 4;
    localparam int SUM_W       = 64;
    localparam int NUM_AXES    = 3;
    localparam int NUM_COMP    = 6;

    // stream payload widths (input padded to whole bytes)
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = NUM_COMP * SUM_W;

    // defaults and sizes
    localparam int BLOCK_SIZE_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_VOL  = 3'd6;

    // one cell as it travels from the front to the back
    typedef struct packed {
        logic [DATA_W-1:0]                density;
        logic [NUM_AXES-1:0][DATA_W-1:0]  vel;
        logic [NUM_AXES-1:0][IDX_W-1:0]   idx;
        logic                             clear;
        logic                             last;
    } t_cell;

    // mesh block geometry
    typedef struct packed {
        logic [NUM_AXES-1:0][DATA_W-1:0] origin;
        logic [NUM_AXES-1:0][DATA_W-1:0] spacing;
        logic [DATA_W-1:0]               cell_volume;
    } t_cfg;

endpackage

@@ rtl/core/quadrupole_rate_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrupole_rate_accumulator
// Streams mesh cells and accumulates the six components of the traceless
// mass quadrupole-rate tensor in saturating Q32.32 sums.
// ----------------------------------------------------------------------------
// Each cell request passes through the back end in order: ten products per
// cell through the single shared 33x33 multiplier (mass and the nine
// velocity-coordinate products), term setup, a radix-256 divide-by-three,
// then four 32-bit partial products per tensor component with clamp and
// sum. A cell that carries last adds an emit step, which waits while the
// result register is still held by the sink. A front register and a
// two-entry queue take up to three cells ahead of the back end, so the
// source sees ready while a cell is being worked. The user must write the
// geometry registers only while the block is idle between mesh blocks; the
// block does not enforce this. The configuration channel is always ready.
// ----------------------------------------------------------------------------
module quadrupole_rate_accumulator #(
    parameter int BLOCK_SIZE = qra_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cell requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // density, vel_x, vel_y, vel_z, index_i, index_j, index_k, zero pad
    input  logic [qra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,   // clear
    input  logic                              s_axis_tlast,   // last
    // tensor sums
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sum_xx, sum_xy, sum_xz, sum_yy, sum_yz, sum_zz
    output logic [qra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qra_pkg::DATA_W-1:0]        i_cfg_data
);
    import qra_pkg::*;

    t_cfg  r_cfg;
    t_cell front_cell, queue_cell;
    logic  front_vld, queue_rdy;
    logic  queue_vld, back_rdy;
    logic  cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // geometry registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_cfg.origin[0]   <= i_cfg_data;
                CFG_ORIGIN_Y:  r_cfg.origin[1]   <= i_cfg_data;
                CFG_ORIGIN_Z:  r_cfg.origin[2]   <= i_cfg_data;
                CFG_SPACING_X: r_cfg.spacing[0]  <= i_cfg_data;
                CFG_SPACING_Y: r_cfg.spacing[1]  <= i_cfg_data;
                CFG_SPACING_Z: r_cfg.spacing[2]  <= i_cfg_data;
                CFG_CELL_VOL:  r_cfg.cell_volume <= i_cfg_data;
                default:       r_cfg             <= r_cfg;
            endcase
        end
    end

    qra_front #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_vld         (front_vld),
        .i_rdy         (queue_rdy),
        .o_cell        (front_cell)
    );

    qra_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .o_push_rdy (queue_rdy),
        .i_cell     (front_cell),
        .o_pop_vld  (queue_vld),
        .i_pop_rdy  (back_rdy),
        .o_cell     (queue_cell)
    );

    qra_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_vld    (queue_vld),
        .o_q_rdy    (back_rdy),
        .i_cell     (queue_cell),
        .o_out_vld  (m_axis_tvalid),
        .i_out_rdy  (m_axis_tready),
        .o_out_data (m_axis_tdata)
    );

endmodule

@@ rtl/core/qra_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_front
// Input stage: takes cell requests off the stream, unpacks the payload and
// clamps the cell indexes to the block, holding one cell in a register.
// ----------------------------------------------------------------------------
module qra_front #(
    parameter int BLOCK_SIZE = qra_pkg::BLOCK_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // density, vel_x, vel_y, vel_z, index_i, index_j, index_k, zero pad
    input  logic [qra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,   // clear
    input  logic                             s_axis_tlast,   // last
    output logic                             o_vld,
    input  logic                             i_rdy,
    output qra_pkg::t_cell                   o_cell
);
    import qra_pkg::*;

    localparam logic [6:0] IdxLim = 7'(BLOCK_SIZE - 1);

    logic  r_vld;
    t_cell r_cell;
    t_cell cell_in;
    logic  accept;

    function automatic logic [IDX_W-1:0] f_clamp_idx(input logic [IDX_W-1:0] idx);
        begin
            if (7'(idx) > IdxLim) begin
                return IdxLim[IDX_W-1:0];
            end
            return idx;
        end
    endfunction

    // unpack and classify
    always_comb begin
        cell_in.density = s_axis_tdata[31:0];
        cell_in.vel[0]  = s_axis_tdata[63:32];
        cell_in.vel[1]  = s_axis_tdata[95:64];
        cell_in.vel[2]  = s_axis_tdata[127:96];
        cell_in.idx[0]  = f_clamp_idx(s_axis_tdata[131:128]);
        cell_in.idx[1]  = f_clamp_idx(s_axis_tdata[135:132]);
        cell_in.idx[2]  = f_clamp_idx(s_axis_tdata[139:136]);
        cell_in.clear   = s_axis_tuser;
        cell_in.last    = s_axis_tlast;
    end

    assign s_axis_tready = !r_vld || i_rdy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell <= cell_in;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

@@ rtl/core/qra_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_queue
// Short FIFO of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module qra_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_vld,
    output logic            o_push_rdy,
    input  qra_pkg::t_cell  i_cell,
    output logic            o_pop_vld,
    input  logic            i_pop_rdy,
    output qra_pkg::t_cell  o_cell
);
    import qra_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    t_cell           r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            push, pop;

    assign o_push_rdy = (r_count != CntFull);
    assign o_pop_vld  = (r_count != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_cell     = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PtrLast) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PtrLast) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_cell;
        end
    end

endmodule

@@ rtl/core/qra_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_back
// Execution sequencer: cell coordinates, velocity-coordinate products through
// one shared 33x33 multiplier, divide-by-three, contribution products split
// into 32-bit partials, saturating tensor sums and the result register.
// ----------------------------------------------------------------------------
module qra_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qra_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_vld,
    output logic                              o_q_rdy,
    input  qra_pkg::t_cell                    i_cell,
    output logic                              o_out_vld,
    input  logic                              i_out_rdy,
    output logic [qra_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import qra_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_TERM = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PROD = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // contribution phases: four partial products issued, then accumulated, clamped and summed
    localparam logic [2:0] PH_LL    = 3'd0;
    localparam logic [2:0] PH_LH    = 3'd1;
    localparam logic [2:0] PH_HL    = 3'd2;
    localparam logic [2:0] PH_HH    = 3'd3;
    localparam logic [2:0] PH_ACC   = 3'd4;
    localparam logic [2:0] PH_CLAMP = 3'd5;
    localparam logic [2:0] PH_SUM   = 3'd6;

    // tensor components, in output order
    localparam logic [2:0] T_XX = 3'd0;
    localparam logic [2:0] T_XY = 3'd1;
    localparam logic [2:0] T_XZ = 3'd2;
    localparam logic [2:0] T_YY = 3'd3;
    localparam logic [2:0] T_YZ = 3'd4;
    localparam logic [2:0] T_ZZ = 3'd5;

    // product slots p[a][b] at a*3+b
    localparam int P00 = 0, P01 = 1, P02 = 2, P10 = 3, P11 = 4;
    localparam int P12 = 5, P20 = 6, P21 = 7, P22 = 8;

    localparam int PW       = 48;   // rounded velocity-coordinate product
    localparam int DmW      = 48;   // rounded cell mass
    localparam int MagW     = 49;   // term magnitude
    localparam int AccW     = 98;   // full mass-term product
    localparam int DivW     = 56;
    localparam int DivBits  = 8;
    localparam int DivSteps = DivW / DivBits;

    localparam logic [3:0] MulIssueLast = 4'd9;
    localparam logic [3:0] MulLast      = 4'd10;
    localparam logic [3:0] DivLast      = 4'(DivSteps - 1);
    localparam logic [2:0] TermLast     = 3'(NUM_COMP - 1);

    // row and column of each velocity-coordinate product, slot 0 lowest
    localparam logic [8:0][1:0] ProdRow =
        {2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [8:0][1:0] ProdCol =
        {2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

    // control
    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_ph, n_ph;
    logic [2:0] r_tn, n_tn;
    logic       r_out_vld, n_out_vld;
    logic       out_load, out_free, pop;

    // datapath
    logic [DATA_W-1:0]                 r_dens;
    logic [NUM_AXES-1:0][DATA_W-1:0]   r_v;
    logic [NUM_AXES-1:0][DATA_W-1:0]   r_x;
    logic                              r_last;
    logic signed [65:0]                r_prod;
    logic [DmW-1:0]                    r_dm;
    logic [8:0][PW-1:0]                r_p;
    logic [NUM_AXES-1:0][DivW-1:0]     r_dv;
    logic [NUM_AXES-1:0][1:0]          r_rem;
    logic [NUM_AXES-1:0]               r_dneg;
    logic [NUM_COMP-1:0][MagW-1:0]     r_tmag;
    logic [NUM_COMP-1:0]               r_tneg;
    logic [AccW-1:0]                   r_acc;
    logic [SUM_W-1:0]                  r_contrib;
    logic [NUM_COMP-1:0][SUM_W-1:0]    r_sum;
    logic [OUT_TDATA_W-1:0]            r_out_data;

    logic signed [32:0] mul_a, mul_b;
    logic [3:0]         mul_k;
    logic [3:0]         p_slot;
    logic [1:0]         row, col;
    logic [MagW-1:0]    tmag;
    logic [DmW-1:0]     dm_rnd_w;
    logic [65:0]        dm_sum, p_sum;
    logic [63:0]        pp;
    logic [NUM_AXES-1:0][DivW-1:0] div_next;
    logic [NUM_AXES-1:0][1:0]      rem_next;
    logic [56:0] diag0, diag1, diag2;
    logic [49:0] off01, off02, off12;

    // ------------------------------------------------------------------
    // helper functions
    // ------------------------------------------------------------------

    // origin + (index + 0.5) * spacing, saturated to 32 bits
    function automatic logic [DATA_W-1:0] f_coord(
        input logic [DATA_W-1:0] org,
        input logic [DATA_W-1:0] sp,
        input logic [IDX_W-1:0]  idx
    );
        logic [36:0] half2;
        logic [37:0] x;
        begin
            half2 = 37'({idx, 1'b1}) * 37'(sp);
            x     = {{6{org[31]}}, org} + {2'b00, half2[36:1]};
            if (!x[37] && (x[36:31] != 6'h00)) begin
                return 32'h7FFF_FFFF;
            end else if (x[37] && (x[36:31] != 6'h3F)) begin
                return 32'h8000_0000;
            end
            return x[31:0];
        end
    endfunction

    // diagonal numerator 2*(2a - b - c): {sign, |d| + 1}
    function automatic logic [56:0] f_diag(
        input logic [PW-1:0] pa,
        input logic [PW-1:0] pb,
        input logic [PW-1:0] pc
    );
        logic [51:0] d;
        logic [51:0] mag;
        begin
            d   = (({{4{pa[PW-1]}}, pa} << 1) - {{4{pb[PW-1]}}, pb}
                   - {{4{pc[PW-1]}}, pc}) << 1;
            mag = d[51] ? (~d + 52'd1) : d;
            return {d[51], 56'(mag) + 56'd1};
        end
    endfunction

    // off-diagonal term a + b: {sign, |t|}
    function automatic logic [49:0] f_off(
        input logic [PW-1:0] pa,
        input logic [PW-1:0] pb
    );
        logic [49:0] t;
        logic [49:0] mag;
        begin
            t   = {{2{pa[PW-1]}}, pa} + {{2{pb[PW-1]}}, pb};
            mag = t[49] ? (~t + 50'd1) : t;
            return {t[49], mag[MagW-1:0]};
        end
    endfunction

    // eight bits of restoring division by three: {remainder, quotient bits}
    function automatic logic [9:0] f_div3_step(
        input logic [1:0]         rem,
        input logic [DivBits-1:0] bits
    );
        logic [2:0]         r;
        logic [DivBits-1:0] q;
        begin
            r = {1'b0, rem};
            q = '0;
            for (int i = DivBits - 1; i >= 0; i--) begin
                r = {r[1:0], bits[i]};
                if (r >= 3'd3) begin
                    q[i] = 1'b1;
                    r    = r - 3'd3;
                end
            end
            return {r[1:0], q};
        end
    endfunction

    // signed contribution from magnitude, saturated to 64 bits
    function automatic logic [SUM_W-1:0] f_clamp(
        input logic [AccW-1:0] acc,
        input logic            neg
    );
        begin
            if (!neg) begin
                if (|acc[AccW-1:63]) begin
                    return 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return acc[63:0];
            end
            if ((|acc[AccW-1:64]) || (acc[63] && (|acc[62:0]))) begin
                return 64'h8000_0000_0000_0000;
            end
            return ~acc[63:0] + 64'd1;
        end
    endfunction

    // saturating signed 64-bit add
    function automatic logic [SUM_W-1:0] f_sat_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W:0] s;
        begin
            s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
            if (s[SUM_W] != s[SUM_W-1]) begin
                return s[SUM_W] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            return s[SUM_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign o_q_rdy  = (r_state == S_IDLE);
    assign pop      = o_q_rdy && i_q_vld;
    assign out_free = !r_out_vld || i_out_rdy;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ph     = r_ph;
        n_tn     = r_tn;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                if (r_cnt == MulLast) begin
                    n_state = S_TERM;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_TERM: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (r_cnt == DivLast) begin
                    n_state = S_PROD;
                    n_ph    = PH_LL;
                    n_tn    = T_XX;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_PROD: begin
                if (r_ph == PH_SUM) begin
                    n_ph = PH_LL;
                    if (r_tn == TermLast) begin
                        n_state = r_last ? S_EMIT : S_IDLE;
                    end else begin
                        n_tn = r_tn + 3'd1;
                    end
                end else begin
                    n_ph = r_ph + 3'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_rdy) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // control registers and tensor sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ph      <= PH_LL;
            r_tn      <= T_XX;
            r_out_vld <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ph      <= n_ph;
            r_tn      <= n_tn;
            r_out_vld <= n_out_vld;
            if (pop && i_cell.clear) begin
                r_sum <= '0;
            end else if (r_state == S_PROD && r_ph == PH_SUM) begin
                r_sum[r_tn] <= f_sat_add(r_sum[r_tn], r_contrib);
            end
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    assign mul_k = r_cnt - 4'd1;
    assign row   = ProdRow[mul_k];
    assign col   = ProdCol[mul_k];
    assign tmag  = r_tmag[r_tn];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL: begin
                if (r_cnt == '0) begin
                    // cell mass
                    mul_a = $signed({1'b0, r_dens});
                    mul_b = $signed({1'b0, i_cfg.cell_volume});
                end else if (r_cnt <= MulIssueLast) begin
                    mul_a = $signed({r_v[row][DATA_W-1], r_v[row]});
                    mul_b = $signed({r_x[col][DATA_W-1], r_x[col]});
                end
            end
            S_PROD: begin
                case (r_ph)
                    PH_LL: begin
                        mul_a = $signed({1'b0, tmag[31:0]});
                        mul_b = $signed({1'b0, r_dm[31:0]});
                    end
                    PH_LH: begin
                        mul_a = $signed({1'b0, tmag[31:0]});
                        mul_b = $signed(33'(r_dm[DmW-1:32]));
                    end
                    PH_HL: begin
                        mul_a = $signed(33'(tmag[MagW-1:32]));
                        mul_b = $signed({1'b0, r_dm[31:0]});
                    end
                    PH_HH: begin
                        mul_a = $signed(33'(tmag[MagW-1:32]));
                        mul_b = $signed(33'(r_dm[DmW-1:32]));
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding of products: add half an LSB of Q.16, then floor
    assign dm_sum   = {2'b00, r_prod[63:0]} + 66'h8000;
    assign dm_rnd_w = dm_sum[63:16];
    assign p_sum    = r_prod + 66'h8000;
    assign p_slot   = r_cnt - 4'd2;
    assign pp       = r_prod[63:0];

    // term setup from the stored products
    assign diag0 = f_diag(r_p[P00], r_p[P11], r_p[P22]);
    assign diag1 = f_diag(r_p[P11], r_p[P00], r_p[P22]);
    assign diag2 = f_diag(r_p[P22], r_p[P00], r_p[P11]);
    assign off01 = f_off(r_p[P01], r_p[P10]);
    assign off02 = f_off(r_p[P02], r_p[P20]);
    assign off12 = f_off(r_p[P12], r_p[P21]);

    // divide-by-three lanes, eight dividend bits a cycle
    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            {rem_next[l], div_next[l][DivBits-1:0]} =
                f_div3_step(r_rem[l], r_dv[l][DivW-1:DivW-DivBits]);
            div_next[l][DivW-1:DivBits] = r_dv[l][DivW-DivBits-1:0];
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        // load cell and derive centre coordinates
        if (pop) begin
            r_dens <= i_cell.density;
            r_v    <= i_cell.vel;
            r_last <= i_cell.last;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_x[a] <= f_coord(i_cfg.origin[a], i_cfg.spacing[a], i_cell.idx[a]);
            end
        end

        // collect products in the cycle after issue
        if (r_state == S_MUL && r_cnt != '0) begin
            if (r_cnt == 4'd1) begin
                r_dm <= dm_rnd_w;
            end else begin
                r_p[p_slot] <= p_sum[63:16];
            end
        end

        // terms: off-diagonal magnitudes now, diagonal numerators to the divider
        if (r_state == S_TERM) begin
            {r_tneg[T_XY], r_tmag[T_XY]} <= off01;
            {r_tneg[T_XZ], r_tmag[T_XZ]} <= off02;
            {r_tneg[T_YZ], r_tmag[T_YZ]} <= off12;
            {r_dneg[0], r_dv[0]}         <= diag0;
            {r_dneg[1], r_dv[1]}         <= diag1;
            {r_dneg[2], r_dv[2]}         <= diag2;
            r_rem                        <= '0;
        end

        if (r_state == S_DIV) begin
            r_dv  <= div_next;
            r_rem <= rem_next;
            if (r_cnt == DivLast) begin
                r_tmag[T_XX] <= div_next[0][MagW-1:0];
                r_tmag[T_YY] <= div_next[1][MagW-1:0];
                r_tmag[T_ZZ] <= div_next[2][MagW-1:0];
                r_tneg[T_XX] <= r_dneg[0];
                r_tneg[T_YY] <= r_dneg[1];
                r_tneg[T_ZZ] <= r_dneg[2];
            end
        end

        // mass times term: partial products arrive in the phase after issue
        if (r_state == S_PROD) begin
            case (r_ph)
                PH_LH:    r_acc <= AccW'(pp);
                PH_HL:    r_acc <= r_acc + (AccW'(pp) << 32);
                PH_HH:    r_acc <= r_acc + (AccW'(pp) << 32);
                PH_ACC:   r_acc <= r_acc + (AccW'(pp) << 64);
                PH_CLAMP: r_contrib <= f_clamp(r_acc, r_tneg[r_tn]);
                default:  r_acc <= r_acc;
            endcase
        end

        // result register, xx in the lowest bits
        if (out_load) begin
            r_out_data <= r_sum;
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out_data;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_vld) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit step");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == S_MUL && r_cnt == '0))
        else $error("popped cell did not start the product pass");

    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_last)
        else $error("emit reached without a last cell");

    a_sums_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_TERM || r_state == S_DIV) |=> $stable(r_sum))
        else $error("tensor sums changed before the contribution pass");

    a_pos_contrib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD && r_ph == PH_SUM && !r_tneg[r_tn]) |-> !r_contrib[SUM_W-1])
        else $error("nonnegative term gave a negative contribution");

endmodule
